[hdl/lz3_stream_decompressor_assert.svh]
// Assertion macros for the LZ3 stream decompressor checks.
`ifndef LZ3_STREAM_DECOMPRESSOR_ASSERT_SVH
`define LZ3_STREAM_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define LZ3_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define LZ3_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/lz3_pkg.sv]
// Shared types, codes and helpers for the LZ3 stream decompressor.
package lz3_pkg;

   localparam int LANES = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_FILL,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_LONG_LEN,
      PH_LITERAL,
      PH_FILL,
      PH_WORD2,
      PH_OFS_HIGH,
      PH_OFS_LOW
   } phase_type;

   // command codes
   localparam logic [2:0] CMD_LITERAL = 3'd0;
   localparam logic [2:0] CMD_FILL    = 3'd1;
   localparam logic [2:0] CMD_WORD    = 3'd2;
   localparam logic [2:0] CMD_ZERO    = 3'd3;
   localparam logic [2:0] CMD_REPEAT  = 3'd4;
   localparam logic [2:0] CMD_FLIP    = 3'd5;
   localparam logic [2:0] CMD_BACK    = 3'd6;
   localparam logic [2:0] CMD_LONG    = 3'd7;

   // error codes
   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_START = 3'd1;
   localparam logic [2:0] ERR_END   = 3'd2;
   localparam logic [2:0] ERR_SUB7  = 3'd3;
   localparam logic [2:0] ERR_FULL  = 3'd4;

   localparam logic [7:0] END_MARK = 8'hFF;

   // bit-reverse one byte
   function automatic logic [7:0] flip_bits(input logic [7:0] b);
      logic [7:0] r;
      for (int k = 0; k < 8; k++) begin
         r[k] = b[7 - k];
      end
      return r;
   endfunction

endpackage

[hdl/lz3_ram.sv]
// Generic single-port-write, registered-read RAM.
module lz3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/lz3_stream_decompressor.sv]
// Top level of the LZ3 stream decompressor: parser, run sequencer, chunk packer.
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tdata: in_byte; tuser: stream_start
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata: chunk bytes, byte_count;
//          |     | rsp_tlast = last_chunk | tuser: stream_done, error_code
//
// Header and operand bytes are taken in ST_IDLE; a literal byte is accepted, then
// emitted. Fill runs write 1 byte a cycle outside emits; repeat runs pass ST_READ
// then ST_COPY per byte, as the history RAM's registered read feeds its own write port.
// Each chunk of up to 16 bytes passes ST_EMIT, which waits while rsp is stalled.
// Synchronous reset clears control state; history holds no valid bits and
// needs no clearing pass. req_tready is high only while the sequencer is idle.
module lz3_stream_decompressor
   import lz3_pkg::*;
#(
   parameter int HISTORY_DEPTH = 32768
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] in_byte
   input  logic [0:0]   req_tuser,   // [0] stream_start
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // [63:0] bytes_low, [127:64] bytes_high,
                                     // [132:128] byte_count, rest zero
   output logic [3:0]   rsp_tuser,   // [0] stream_done, [3:1] error_code
   output logic         rsp_tlast    // last_chunk
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam int XW = (CW + 1 > 16) ? CW + 1 : 16;
   localparam logic [XW-1:0] DEPTH_X = XW'(HISTORY_DEPTH);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic                halted_ff, halted_in;
   logic [CW-1:0]       wc_ff, wc_in;
   logic [2:0]          cmd_ff, cmd_in;
   logic [10:0]         runlen_ff, runlen_in;
   logic [10:0]         lit_left_ff, lit_left_in;
   logic [7:0]          first_ff, first_in;
   logic [6:0]          ofs_high_ff, ofs_high_in;
   logic [10:0]         run_left_ff, run_left_in;
   logic [AW-1:0]       src_ff, src_in;
   logic [7:0]          fill_a_ff, fill_a_in, fill_b_ff, fill_b_in;
   logic                parity_ff, parity_in;
   logic [LANES-1:0][7:0] lanes_ff, lanes_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic [2:0]          err_ff, err_in;
   logic                out_valid_ff, out_valid_in;
   logic [127:0]        out_lanes_ff, out_lanes_in;
   logic [4:0]          out_cnt_ff, out_cnt_in;
   logic                out_done_ff, out_done_in;
   logic [2:0]          out_err_ff, out_err_in;
   logic                out_last_ff, out_last_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;

   lz3_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_history (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_cnt_ff, out_lanes_ff};
   assign rsp_tuser  = {out_err_ff, out_done_ff};
   assign rsp_tlast  = out_last_ff;

   // parser and run sequencer
   always_comb begin
      logic [7:0]    in_byte;
      logic [CW-1:0] wc_cur;
      phase_type     phase_eff;
      logic          halt_eff;
      logic          do_begin, do_fill, do_rep, raise, done, app_en;
      logic [2:0]    bc_cmd, err_code;
      logic [10:0]   bc_len, fl_len;
      logic [7:0]    fa, fb, app_byte;
      logic [XW-1:0] rstart;

      in_byte   = req_tdata;
      wc_cur    = wc_ff;
      phase_eff = phase_ff;
      halt_eff  = halted_ff;
      do_begin  = 1'b0;
      do_fill   = 1'b0;
      do_rep    = 1'b0;
      raise     = 1'b0;
      done      = 1'b0;
      app_en    = 1'b0;
      bc_cmd    = CMD_LITERAL;
      err_code  = ERR_NONE;
      bc_len    = '0;
      fl_len    = runlen_ff;
      fa        = '0;
      fb        = '0;
      app_byte  = '0;
      rstart    = '0;

      state_in     = state_ff;
      phase_in     = phase_ff;
      halted_in    = halted_ff;
      wc_in        = wc_ff;
      cmd_in       = cmd_ff;
      runlen_in    = runlen_ff;
      lit_left_in  = lit_left_ff;
      first_in     = first_ff;
      ofs_high_in  = ofs_high_ff;
      run_left_in  = run_left_ff;
      src_in       = src_ff;
      fill_a_in    = fill_a_ff;
      fill_b_in    = fill_b_ff;
      parity_in    = parity_ff;
      lanes_in     = lanes_ff;
      cnt_in       = cnt_ff;
      done_in      = done_ff;
      err_in       = err_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      out_lanes_in = out_lanes_ff;
      out_cnt_in   = out_cnt_ff;
      out_done_in  = out_done_ff;
      out_err_in   = out_err_ff;
      out_last_in  = out_last_ff;
      ram_raddr    = src_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               // stream start clears the count and the parse state first
               if (req_tuser[0]) begin
                  wc_cur    = '0;
                  phase_eff = PH_HEADER;
                  halt_eff  = 1'b0;
               end
               wc_in     = wc_cur;
               phase_in  = phase_eff;
               halted_in = halt_eff;
               if (!halt_eff) begin
                  case (phase_eff)
                     PH_HEADER: begin
                        if (in_byte == END_MARK) begin
                           done = 1'b1;
                        end else if (in_byte[7:5] == CMD_LONG) begin
                           cmd_in    = in_byte[4:2];
                           runlen_in = {1'b0, in_byte[1:0], 8'd0};
                           phase_in  = PH_LONG_LEN;
                        end else begin
                           do_begin = 1'b1;
                           bc_cmd   = in_byte[7:5];
                           bc_len   = {6'd0, in_byte[4:0]} + 11'd1;
                        end
                     end
                     PH_LONG_LEN: begin
                        if (cmd_ff == CMD_LONG) begin
                           raise    = 1'b1;
                           err_code = ERR_SUB7;
                        end else begin
                           do_begin = 1'b1;
                           bc_cmd   = cmd_ff;
                           bc_len   = (runlen_ff | {3'd0, in_byte}) + 11'd1;
                        end
                     end
                     PH_LITERAL: begin
                        if (XW'(wc_cur) >= DEPTH_X) begin
                           raise    = 1'b1;
                           err_code = ERR_FULL;
                        end else begin
                           app_en      = 1'b1;
                           app_byte    = in_byte;
                           run_left_in = '0;
                           state_in    = ST_EMIT;
                           if (lit_left_ff > 11'd0) begin
                              lit_left_in = lit_left_ff - 11'd1;
                           end
                           if (lit_left_ff <= 11'd1) begin
                              phase_in = PH_HEADER;
                           end
                        end
                     end
                     PH_FILL: begin
                        if (cmd_ff == CMD_FILL) begin
                           do_fill = 1'b1;
                           fa      = in_byte;
                           fb      = in_byte;
                        end else begin
                           first_in = in_byte;
                           phase_in = PH_WORD2;
                        end
                     end
                     PH_WORD2: begin
                        do_fill = 1'b1;
                        fa      = first_ff;
                        fb      = in_byte;
                     end
                     PH_OFS_HIGH: begin
                        if (in_byte[7]) begin
                           if (XW'(in_byte[6:0]) + XW'(1) > XW'(wc_cur)) begin
                              raise    = 1'b1;
                              err_code = ERR_START;
                           end else begin
                              do_rep = 1'b1;
                              rstart = XW'(wc_cur) - XW'(in_byte[6:0]) - XW'(1);
                           end
                        end else begin
                           ofs_high_in = in_byte[6:0];
                           phase_in    = PH_OFS_LOW;
                        end
                     end
                     PH_OFS_LOW: begin
                        rstart = XW'({ofs_high_ff, in_byte});
                        if (rstart >= XW'(wc_cur)) begin
                           raise    = 1'b1;
                           err_code = ERR_START;
                        end else begin
                           do_rep = 1'b1;
                        end
                     end
                     default: begin
                        phase_in = PH_HEADER;
                     end
                  endcase

                  // command setup after a full header
                  if (do_begin) begin
                     cmd_in    = bc_cmd;
                     runlen_in = bc_len;
                     case (bc_cmd)
                        CMD_LITERAL: begin
                           lit_left_in = bc_len;
                           phase_in    = PH_LITERAL;
                        end
                        CMD_FILL, CMD_WORD: begin
                           phase_in = PH_FILL;
                        end
                        CMD_ZERO: begin
                           do_fill = 1'b1;
                           fl_len  = bc_len;
                        end
                        default: begin
                           phase_in = PH_OFS_HIGH;
                        end
                     endcase
                  end

                  // fill run start
                  if (do_fill) begin
                     phase_in = PH_HEADER;
                     if (XW'(wc_cur) + XW'(fl_len) > DEPTH_X) begin
                        raise    = 1'b1;
                        err_code = ERR_FULL;
                     end else begin
                        fill_a_in   = fa;
                        fill_b_in   = fb;
                        parity_in   = 1'b0;
                        run_left_in = fl_len;
                        state_in    = ST_FILL;
                     end
                  end

                  // repeat run start, checks in order end then full
                  if (do_rep) begin
                     phase_in = PH_HEADER;
                     if (cmd_ff == CMD_FLIP &&
                         rstart + XW'(runlen_ff) > XW'(wc_cur)) begin
                        raise    = 1'b1;
                        err_code = ERR_END;
                     end else if (cmd_ff == CMD_BACK &&
                                  XW'(runlen_ff) > rstart + XW'(1)) begin
                        raise    = 1'b1;
                        err_code = ERR_END;
                     end else if (XW'(wc_cur) + XW'(runlen_ff) > DEPTH_X) begin
                        raise    = 1'b1;
                        err_code = ERR_FULL;
                     end else begin
                        src_in      = rstart[AW-1:0];
                        run_left_in = runlen_ff;
                        state_in    = ST_READ;
                     end
                  end

                  // end marker or error: one empty result, then halt
                  if (raise || done) begin
                     halted_in   = 1'b1;
                     phase_in    = PH_HEADER;
                     done_in     = done;
                     err_in      = err_code;
                     run_left_in = '0;
                     state_in    = ST_EMIT;
                  end
               end
            end
         end
         ST_READ: begin
            ram_raddr = src_ff;
            src_in    = (cmd_ff == CMD_BACK) ? src_ff - AW'(1) : src_ff + AW'(1);
            state_in  = ST_COPY;
         end
         ST_COPY: begin
            app_en      = 1'b1;
            app_byte    = (cmd_ff == CMD_FLIP) ? flip_bits(ram_rdata) : ram_rdata;
            run_left_in = run_left_ff - 11'd1;
            state_in    = (cnt_ff == 5'd15 || run_left_ff == 11'd1) ? ST_EMIT : ST_READ;
         end
         ST_FILL: begin
            app_en      = 1'b1;
            app_byte    = parity_ff ? fill_b_ff : fill_a_ff;
            parity_in   = ~parity_ff;
            run_left_in = run_left_ff - 11'd1;
            state_in    = (cnt_ff == 5'd15 || run_left_ff == 11'd1) ? ST_EMIT : ST_FILL;
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_lanes_in = lanes_ff;
               out_cnt_in   = cnt_ff;
               out_done_in  = done_ff;
               out_err_in   = err_ff;
               out_last_in  = (run_left_ff == 11'd0);
               lanes_in     = '0;
               cnt_in       = '0;
               done_in      = 1'b0;
               err_in       = ERR_NONE;
               if (run_left_ff == 11'd0) begin
                  state_in = ST_IDLE;
               end else if (cmd_ff <= CMD_ZERO) begin
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // append one output byte to history and the chunk
      ram_we    = app_en;
      ram_waddr = wc_cur[AW-1:0];
      ram_wdata = app_byte;
      if (app_en) begin
         lanes_in[cnt_ff[3:0]] = app_byte;
         cnt_in                = cnt_ff + 5'd1;
         wc_in                 = wc_cur + CW'(1);
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_HEADER;
         halted_ff    <= 1'b0;
         wc_ff        <= '0;
         cmd_ff       <= CMD_LITERAL;
         runlen_ff    <= '0;
         lit_left_ff  <= '0;
         first_ff     <= '0;
         ofs_high_ff  <= '0;
         run_left_ff  <= '0;
         parity_ff    <= 1'b0;
         lanes_ff     <= '0;
         cnt_ff       <= '0;
         done_ff      <= 1'b0;
         err_ff       <= ERR_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         halted_ff    <= halted_in;
         wc_ff        <= wc_in;
         cmd_ff       <= cmd_in;
         runlen_ff    <= runlen_in;
         lit_left_ff  <= lit_left_in;
         first_ff     <= first_in;
         ofs_high_ff  <= ofs_high_in;
         run_left_ff  <= run_left_in;
         parity_ff    <= parity_in;
         lanes_ff     <= lanes_in;
         cnt_ff       <= cnt_in;
         done_ff      <= done_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      fill_a_ff    <= fill_a_in;
      fill_b_ff    <= fill_b_in;
      out_lanes_ff <= out_lanes_in;
      out_cnt_ff   <= out_cnt_in;
      out_done_ff  <= out_done_in;
      out_err_ff   <= out_err_in;
      out_last_ff  <= out_last_in;
   end

endmodule

[hdl/lz3_checker.sv]
// Port-level checks on the result channel, bound to the top level.
`include "lz3_stream_decompressor_assert.svh"

module lz3_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic [3:0]   rsp_tuser,
   input logic         rsp_tlast
);

   // a stalled result holds
   `LZ3_ASSERT_NEXT(a_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "rsp changed while stalled")
   // a chunk never carries more than sixteen bytes
   `LZ3_ASSERT_NOW(a_count, rsp_tvalid, rsp_tdata[132:128] <= 5'd16, "byte_count above 16")
   // end or error only on the final result
   `LZ3_ASSERT_NOW(a_status_last, rsp_tvalid && rsp_tuser != 4'd0, rsp_tlast, "status on non-final result")
   // end or error results carry no bytes
   `LZ3_ASSERT_NOW(a_status_empty, rsp_tvalid && rsp_tuser != 4'd0, rsp_tdata[132:128] == 5'd0 && rsp_tdata[127:0] == 128'd0, "status result with bytes")

endmodule

bind lz3_stream_decompressor lz3_checker u_lz3_checker (.*);
